FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PES_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define PES_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define PES_ASSERT(lbl, clk, rstn, prop)
`define PES_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: hdl/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg
// Types and constants shared by the execute stage modules.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned TagW = 4;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_SLT  = 5'd2,
    OP_SGT  = 5'd3,
    OP_SLE  = 5'd4,
    OP_SGE  = 5'd5,
    OP_AND  = 5'd6,
    OP_OR   = 5'd7,
    OP_NOR  = 5'd8,
    OP_XOR  = 5'd9,
    OP_SLL  = 5'd10,
    OP_SRA  = 5'd11,
    OP_BEQ  = 5'd12,
    OP_BLT  = 5'd13,
    OP_BGT  = 5'd14,
    OP_BLE  = 5'd15,
    OP_BGE  = 5'd16,
    OP_ORI  = 5'd17,
    OP_ANDI = 5'd18,
    OP_LA   = 5'd19,
    OP_SA   = 5'd20
  } op_e;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic [DataW-1:0] pc_next;
    logic             taken;
    logic             bad;
  } alu_res_t;

endpackage

FILE: hdl/pes_fwd.sv
// ----------------------------------------------------------------------------
// pes_fwd
// Operand bypass select: EX over MEM over WB over the register file value.
// ----------------------------------------------------------------------------
module pes_fwd (
  input  logic [pes_pkg::RegIdxW-1:0] src_i,
  input  logic [pes_pkg::DataW-1:0]   base_i,
  input  logic [3*pes_pkg::TagW-1:0]  tags_i,
  input  logic [pes_pkg::DataW-1:0]   ex_i,
  input  logic [pes_pkg::DataW-1:0]   mem_i,
  input  logic [pes_pkg::DataW-1:0]   wb_i,
  output logic [pes_pkg::DataW-1:0]   value_o
);

  logic [pes_pkg::TagW-1:0] ex_tag, mem_tag, wb_tag;
  logic                     ex_hit, mem_hit, wb_hit;

  assign ex_tag  = tags_i[11:8];
  assign mem_tag = tags_i[7:4];
  assign wb_tag  = tags_i[3:0];

  assign ex_hit  = ex_tag[3]  && (ex_tag[2:0]  == src_i);
  assign mem_hit = mem_tag[3] && (mem_tag[2:0] == src_i);
  assign wb_hit  = wb_tag[3]  && (wb_tag[2:0]  == src_i);

  always_comb begin
    if (ex_hit) begin
      value_o = ex_i;
    end else if (mem_hit) begin
      value_o = mem_i;
    end else if (wb_hit) begin
      value_o = wb_i;
    end else begin
      value_o = base_i;
    end
  end

endmodule

FILE: hdl/pes_alu.sv
// ----------------------------------------------------------------------------
// pes_alu
// Twenty-one operation ALU with branch compare and next pc select.
// ----------------------------------------------------------------------------
module pes_alu (
  input  logic [4:0]                opcode_i,
  input  logic                      jump_i,
  input  logic                      taken_i,
  input  logic [pes_pkg::DataW-1:0] a_i,
  input  logic [pes_pkg::DataW-1:0] b_i,
  input  logic [pes_pkg::DataW-1:0] imm_i,
  input  logic [pes_pkg::DataW-1:0] pc_i,
  output pes_pkg::alu_res_t         res_o
);

  logic signed [pes_pkg::DataW-1:0] a_s, b_s;
  logic                             lt, eq, amt_le0, amt_ge16;
  logic        [3:0]                amt;
  logic        [pes_pkg::DataW-1:0] sll_v, sra_v;
  logic        [pes_pkg::DataW-1:0] res;
  logic                             taken, bad;

  assign a_s   = a_i;
  assign b_s   = b_i;
  assign lt    = a_s < b_s;
  assign eq    = a_i == b_i;
  assign amt   = imm_i[3:0];
  assign amt_le0  = imm_i[15] || (imm_i == '0);
  assign amt_ge16 = !imm_i[15] && (imm_i[14:4] != '0);

  always_comb begin
    if (amt_le0) begin
      sll_v = a_i;
      sra_v = a_i;
    end else if (amt_ge16) begin
      sll_v = '0;
      sra_v = {pes_pkg::DataW{a_i[15]}};
    end else begin
      sll_v = a_i << amt;
      sra_v = a_s >>> amt;
    end
  end

  always_comb begin
    res   = '0;
    taken = taken_i;
    bad   = 1'b0;
    case (pes_pkg::op_e'(opcode_i))
      pes_pkg::OP_ADD:  res = jump_i ? '0 : a_i + b_i;
      pes_pkg::OP_SUB:  res = a_i - b_i;
      pes_pkg::OP_SLT:  res = {15'd0, lt};
      pes_pkg::OP_SGT:  res = {15'd0, !lt && !eq};
      pes_pkg::OP_SLE:  res = {15'd0, lt || eq};
      pes_pkg::OP_SGE:  res = {15'd0, !lt};
      pes_pkg::OP_AND:  res = a_i & b_i;
      pes_pkg::OP_OR:   res = a_i | b_i;
      pes_pkg::OP_NOR:  res = ~(a_i | b_i);
      pes_pkg::OP_XOR:  res = a_i ^ b_i;
      pes_pkg::OP_SLL:  res = sll_v;
      pes_pkg::OP_SRA:  res = sra_v;
      pes_pkg::OP_BEQ:  taken = eq;
      pes_pkg::OP_BLT:  taken = lt;
      pes_pkg::OP_BGT:  taken = !lt && !eq;
      pes_pkg::OP_BLE:  taken = lt || eq;
      pes_pkg::OP_BGE:  taken = !lt;
      pes_pkg::OP_ORI:  res = a_i | imm_i;
      pes_pkg::OP_ANDI: res = a_i & imm_i;
      pes_pkg::OP_LA:   res = a_i + imm_i;
      pes_pkg::OP_SA:   res = a_i + imm_i;
      default:          bad = 1'b1;
    endcase
  end

  assign res_o.result  = res;
  assign res_o.taken   = taken;
  assign res_o.bad     = bad;
  assign res_o.pc_next = taken ? {pc_i[15:8], imm_i[6:0], 1'b0} : pc_i;

endmodule

FILE: hdl/pipeline_execute_stage_top.sv
// ----------------------------------------------------------------------------
// pipeline_execute_stage_top
// Execute stage: operand bypass, ALU, branch resolve, held results on bubbles.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with one instruction word per
// handshake; output channel: out_valid_o / out_stall_i with one result word.
// Every accepted word gives exactly one result word, in order.
// An accepted word is held in the input register; the bypass select and the
// ALU then resolve it into the output register, which raises out_valid_o.
// Throughput is one word per cycle while the receiver takes results; the
// input register and the output register each hold a word, so a new word
// is taken while a result waits. When the receiver stalls, the output
// register holds; the input register fills, and in_stall_o rises only
// when both are full.
// Bubbles and bad opcodes keep the last ALU result; bubbles also keep the
// last pc. Reset empties both registers and clears the held result and pc
// to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pipeline_execute_stage_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        nop_i,
  input  logic [4:0]  opcode_i,
  input  logic [2:0]  control_flags_i,
  input  logic [15:0] instruction_i,
  input  logic [15:0] rs_value_i,
  input  logic [15:0] rt_value_i,
  input  logic [15:0] immediate_i,
  input  logic [15:0] pc_in_i,
  input  logic [15:0] ex_fwd_value_i,
  input  logic [15:0] mem_fwd_value_i,
  input  logic [15:0] wb_fwd_value_i,
  input  logic [11:0] fwd_tags_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] alu_result_o,
  output logic [15:0] pc_out_o,
  output logic        branch_taken_o,
  output logic        bad_opcode_o,
  output logic [15:0] rt_forwarded_o
);

  logic        s1_valid_q;
  logic        nop_q;
  logic [4:0]  opcode_q;
  logic [2:0]  flags_q;
  logic [15:0] instr_q, rs_q, rt_q, imm_q, pc_q, exv_q, memv_q, wbv_q;
  logic [11:0] tags_q;

  logic        out_valid_q;
  logic [15:0] alu_result_q, pc_out_q, rt_fwd_q;
  logic        taken_q, bad_q;
  logic [15:0] held_result_q, held_pc_q;

  logic        in_accept, advance;
  logic [2:0]  rs_idx, rt_idx;
  logic [15:0] rs_fwd, rt_fwd;
  logic [15:0] alu_result_d, pc_out_d, rt_fwd_d;
  logic        taken_d, bad_d;
  pes_pkg::alu_res_t alu_res;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      nop_q    <= nop_i;
      opcode_q <= opcode_i;
      flags_q  <= control_flags_i;
      instr_q  <= instruction_i;
      rs_q     <= rs_value_i;
      rt_q     <= rt_value_i;
      imm_q    <= immediate_i;
      pc_q     <= pc_in_i;
      exv_q    <= ex_fwd_value_i;
      memv_q   <= mem_fwd_value_i;
      wbv_q    <= wb_fwd_value_i;
      tags_q   <= fwd_tags_i;
    end
  end

  assign rs_idx = flags_q[0] ? instr_q[11:9] : instr_q[8:6];
  assign rt_idx = flags_q[0] ? instr_q[8:6]  : instr_q[5:3];

  pes_fwd u_fwd_rs (
    .src_i   (rs_idx),
    .base_i  (rs_q),
    .tags_i  (tags_q),
    .ex_i    (exv_q),
    .mem_i   (memv_q),
    .wb_i    (wbv_q),
    .value_o (rs_fwd)
  );

  pes_fwd u_fwd_rt (
    .src_i   (rt_idx),
    .base_i  (rt_q),
    .tags_i  (tags_q),
    .ex_i    (exv_q),
    .mem_i   (memv_q),
    .wb_i    (wbv_q),
    .value_o (rt_fwd)
  );

  pes_alu u_alu (
    .opcode_i (opcode_q),
    .jump_i   (flags_q[1]),
    .taken_i  (flags_q[2]),
    .a_i      (rs_fwd),
    .b_i      (rt_fwd),
    .imm_i    (imm_q),
    .pc_i     (pc_q),
    .res_o    (alu_res)
  );

  always_comb begin
    if (nop_q) begin
      alu_result_d = held_result_q;
      pc_out_d     = held_pc_q;
      taken_d      = 1'b0;
      bad_d        = 1'b0;
      rt_fwd_d     = '0;
    end else begin
      alu_result_d = alu_res.bad ? held_result_q : alu_res.result;
      pc_out_d     = alu_res.pc_next;
      taken_d      = alu_res.taken;
      bad_d        = alu_res.bad;
      rt_fwd_d     = rt_fwd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      held_result_q <= '0;
      held_pc_q     <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance && !nop_q) begin
        held_pc_q <= pc_out_d;
        if (!alu_res.bad) begin
          held_result_q <= alu_res.result;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      alu_result_q <= alu_result_d;
      pc_out_q     <= pc_out_d;
      taken_q      <= taken_d;
      bad_q        <= bad_d;
      rt_fwd_q     <= rt_fwd_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign alu_result_o   = alu_result_q;
  assign pc_out_o       = pc_out_q;
  assign branch_taken_o = taken_q;
  assign bad_opcode_o   = bad_q;
  assign rt_forwarded_o = rt_fwd_q;

  `PES_ASSERT(a_stall_needs_word, clk_i, rst_ni, in_stall_o |-> s1_valid_q)
  `PES_ASSERT(a_advance_fills_out, clk_i, rst_ni, advance |=> out_valid_o)
  `PES_ASSERT(a_bad_keeps_result, clk_i, rst_ni,
    (out_valid_o && bad_opcode_o) |-> (alu_result_o == held_result_q))
  `PES_ASSERT(a_target_aligned, clk_i, rst_ni,
    (out_valid_o && branch_taken_o) |-> !pc_out_o[0])

endmodule

FILE: tb/pes_result_checker.sv
// ----------------------------------------------------------------------------
// pes_result_checker
// Watches both channels of the execute stage. Each accepted instruction word
// is run through a bypass/ALU/branch predictor with its own held result and
// held pc. The expected result word is queued, and every accepted result
// word is compared with the oldest entry in that queue.
// ----------------------------------------------------------------------------
module pes_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        nop_i,
  input  logic [4:0]  opcode_i,
  input  logic [2:0]  control_flags_i,
  input  logic [15:0] instruction_i,
  input  logic [15:0] rs_value_i,
  input  logic [15:0] rt_value_i,
  input  logic [15:0] immediate_i,
  input  logic [15:0] pc_in_i,
  input  logic [15:0] ex_fwd_value_i,
  input  logic [15:0] mem_fwd_value_i,
  input  logic [15:0] wb_fwd_value_i,
  input  logic [11:0] fwd_tags_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] alu_result_i,
  input  logic [15:0] pc_out_i,
  input  logic        branch_taken_i,
  input  logic        bad_opcode_i,
  input  logic [15:0] rt_forwarded_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [pes_pkg::DataW-1:0] alu_result;
    logic [pes_pkg::DataW-1:0] pc_out;
    logic                      taken;
    logic                      bad;
    logic [pes_pkg::DataW-1:0] rt_fwd;
  } exec_word_t;

  exec_word_t                expected_words[$];
  logic [pes_pkg::DataW-1:0] held_result;
  logic [pes_pkg::DataW-1:0] held_pc;

  function automatic logic [pes_pkg::DataW-1:0] bypass_operand(
    input logic [pes_pkg::RegIdxW-1:0] src,
    input logic [pes_pkg::DataW-1:0]   reg_val,
    input logic [11:0]                 tags,
    input logic [pes_pkg::DataW-1:0]   ex_val,
    input logic [pes_pkg::DataW-1:0]   mem_val,
    input logic [pes_pkg::DataW-1:0]   wb_val
  );
    if (tags[11] && tags[10:8] == src) return ex_val;
    if (tags[7] && tags[6:4] == src) return mem_val;
    if (tags[3] && tags[2:0] == src) return wb_val;
    return reg_val;
  endfunction

  // Work out the result word of the word on the input ports; advance held state unless it is a bubble.
  function automatic exec_word_t predict_execute();
    exec_word_t                       w;
    logic [pes_pkg::RegIdxW-1:0]      rs_idx;
    logic [pes_pkg::RegIdxW-1:0]      rt_idx;
    logic signed [pes_pkg::DataW-1:0] a;
    logic signed [pes_pkg::DataW-1:0] b;
    logic signed [pes_pkg::DataW-1:0] imm;
    logic [pes_pkg::DataW-1:0]        res;
    logic                             taken;
    logic                             bad;
    w = '0;
    if (nop_i) begin
      w.alu_result = held_result;
      w.pc_out = held_pc;
      return w;
    end
    rs_idx = control_flags_i[0] ? instruction_i[11:9] : instruction_i[8:6];
    rt_idx = control_flags_i[0] ? instruction_i[8:6] : instruction_i[5:3];
    a = bypass_operand(rs_idx, rs_value_i, fwd_tags_i, ex_fwd_value_i,
                       mem_fwd_value_i, wb_fwd_value_i);
    b = bypass_operand(rt_idx, rt_value_i, fwd_tags_i, ex_fwd_value_i,
                       mem_fwd_value_i, wb_fwd_value_i);
    imm = immediate_i;
    taken = control_flags_i[2];
    bad = 1'b0;
    res = '0;
    case (opcode_i)
      pes_pkg::OP_ADD:  res = control_flags_i[1] ? 16'd0 : a + b;
      pes_pkg::OP_SUB:  res = a - b;
      pes_pkg::OP_SLT:  res = {15'd0, a < b};
      pes_pkg::OP_SGT:  res = {15'd0, a > b};
      pes_pkg::OP_SLE:  res = {15'd0, a <= b};
      pes_pkg::OP_SGE:  res = {15'd0, a >= b};
      pes_pkg::OP_AND:  res = a & b;
      pes_pkg::OP_OR:   res = a | b;
      pes_pkg::OP_NOR:  res = ~(a | b);
      pes_pkg::OP_XOR:  res = a ^ b;
      pes_pkg::OP_SLL: begin
        if (imm <= 0) res = a;
        else if (imm >= 16) res = '0;
        else res = a << imm[3:0];
      end
      pes_pkg::OP_SRA: begin
        if (imm <= 0) res = a;
        else if (imm >= 16) res = {pes_pkg::DataW{a[pes_pkg::DataW-1]}};
        else res = a >>> imm[3:0];
      end
      pes_pkg::OP_BEQ:  taken = (a == b);
      pes_pkg::OP_BLT:  taken = (a < b);
      pes_pkg::OP_BGT:  taken = (a > b);
      pes_pkg::OP_BLE:  taken = (a <= b);
      pes_pkg::OP_BGE:  taken = (a >= b);
      pes_pkg::OP_ORI:  res = a | imm;
      pes_pkg::OP_ANDI: res = a & imm;
      pes_pkg::OP_LA, pes_pkg::OP_SA: res = a + imm;
      default: bad = 1'b1;
    endcase
    if (!bad) held_result = res;
    held_pc = taken ? {pc_in_i[15:8], immediate_i[6:0], 1'b0} : pc_in_i;
    w.alu_result = held_result;
    w.pc_out = held_pc;
    w.taken = taken;
    w.bad = bad;
    w.rt_fwd = b;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    exec_word_t exp_w;
    exec_word_t got_w;
    if (!rst_ni) begin
      held_result = '0;
      held_pc = '0;
      expected_words.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got_w = '{alu_result_i, pc_out_i, branch_taken_i, bad_opcode_i, rt_forwarded_i};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word alu=%h pc=%h tk=%b bad=%b rt=%h",
                   $time, got_w.alu_result, got_w.pc_out, got_w.taken, got_w.bad,
                   got_w.rt_fwd);
          fail_count_o++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got_w !== exp_w) begin
            $display("%0t: mismatch exp %h/%h/%b/%b/%h got %h/%h/%b/%b/%h",
                     $time, exp_w.alu_result, exp_w.pc_out, exp_w.taken, exp_w.bad,
                     exp_w.rt_fwd, got_w.alu_result, got_w.pc_out, got_w.taken,
                     got_w.bad, got_w.rt_fwd);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_words.push_back(predict_execute());
      pending_o <= expected_words.size();
    end
  end

endmodule

FILE: tb/tb_pipeline_execute_stage_top.sv
// ----------------------------------------------------------------------------
// tb_pipeline_execute_stage_top
// Drives the execute stage with a directed set of instruction words (every
// operation, operand extremes, bypass priority, shift limits, bubbles, bad
// opcodes) and then random words under three idle patterns and a long
// receiver hold-off. A checker module predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_pipeline_execute_stage_top;

  localparam int WatchdogLimit = 2000;
  localparam int HoldOffCycles = 80;

  typedef struct packed {
    logic        nop;
    logic [4:0]  opcode;
    logic [2:0]  flags;
    logic [15:0] instr;
    logic [15:0] rs_val;
    logic [15:0] rt_val;
    logic [15:0] imm;
    logic [15:0] pc;
    logic [15:0] ex_val;
    logic [15:0] mem_val;
    logic [15:0] wb_val;
    logic [11:0] tags;
  } exec_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        nop_i = 1'b0;
  logic [4:0]  opcode_i = '0;
  logic [2:0]  control_flags_i = '0;
  logic [15:0] instruction_i = '0;
  logic [15:0] rs_value_i = '0;
  logic [15:0] rt_value_i = '0;
  logic [15:0] immediate_i = '0;
  logic [15:0] pc_in_i = '0;
  logic [15:0] ex_fwd_value_i = '0;
  logic [15:0] mem_fwd_value_i = '0;
  logic [15:0] wb_fwd_value_i = '0;
  logic [11:0] fwd_tags_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] alu_result_o;
  logic [15:0] pc_out_o;
  logic        branch_taken_o;
  logic        bad_opcode_o;
  logic [15:0] rt_forwarded_o;

  int fail_count;
  int pending;
  int send_idle_pct = 30;
  int recv_idle_pct = 68;
  bit hold_off_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  pipeline_execute_stage_top dut (.*);

  pes_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .nop_i          (nop_i),
    .opcode_i       (opcode_i),
    .control_flags_i(control_flags_i),
    .instruction_i  (instruction_i),
    .rs_value_i     (rs_value_i),
    .rt_value_i     (rt_value_i),
    .immediate_i    (immediate_i),
    .pc_in_i        (pc_in_i),
    .ex_fwd_value_i (ex_fwd_value_i),
    .mem_fwd_value_i(mem_fwd_value_i),
    .wb_fwd_value_i (wb_fwd_value_i),
    .fwd_tags_i     (fwd_tags_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alu_result_i   (alu_result_o),
    .pc_out_i       (pc_out_o),
    .branch_taken_i (branch_taken_o),
    .bad_opcode_i   (bad_opcode_o),
    .rt_forwarded_i (rt_forwarded_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: random stall, or a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HoldOffCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb_pipeline_execute_stage_top: FAIL");
    $finish;
  end

  task automatic drive_word(input exec_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    nop_i <= it.nop;
    opcode_i <= it.opcode;
    control_flags_i <= it.flags;
    instruction_i <= it.instr;
    rs_value_i <= it.rs_val;
    rt_value_i <= it.rt_val;
    immediate_i <= it.imm;
    pc_in_i <= it.pc;
    ex_fwd_value_i <= it.ex_val;
    mem_fwd_value_i <= it.mem_val;
    wb_fwd_value_i <= it.wb_val;
    fwd_tags_i <= it.tags;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic exec_item_t random_item();
    exec_item_t   it;
    logic [2:0]   dest;
    it.nop = ($urandom_range(9) == 0);
    it.opcode = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 21))
                                         : 5'($urandom_range(pes_pkg::OP_SA));
    it.flags = 3'($urandom);
    it.instr = 16'($urandom);
    it.rs_val = pick_value();
    it.rt_val = pick_value();
    if ((it.opcode == pes_pkg::OP_SLL || it.opcode == pes_pkg::OP_SRA) &&
        $urandom_range(1))
      it.imm = 16'($urandom_range(20)) - 16'd2;
    else
      it.imm = pick_value();
    it.pc = 16'($urandom);
    it.ex_val = pick_value();
    it.mem_val = pick_value();
    it.wb_val = pick_value();
    for (int s = 0; s < 3; s++) begin
      case ($urandom_range(3))
        0: dest = it.instr[11:9];
        1: dest = it.instr[8:6];
        2: dest = it.instr[5:3];
        default: dest = 3'($urandom);
      endcase
      it.tags[4*s +: 4] = {1'($urandom), dest};
    end
    return it;
  endfunction

  task automatic run_random(input int n, input int s_pct, input int r_pct);
    wait_drained();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) drive_word(random_item());
  endtask

  task automatic run_directed();
    exec_item_t it;
    for (int op = pes_pkg::OP_ADD; op <= pes_pkg::OP_SA; op++) begin
      it = random_item();
      it.nop = 1'b0;
      it.opcode = 5'(op);
      it.flags = {op[0], 1'b0, op[1]};
      it.tags = '0;
      it.rs_val = op[0] ? 16'h7FFF : 16'h8000;
      it.rt_val = (op % 4 < 2) ? 16'h7FFF : 16'h8000;
      if (op == pes_pkg::OP_BEQ) it.rt_val = it.rs_val;
      if (op == pes_pkg::OP_SLL) it.imm = 16'd16;
      else if (op == pes_pkg::OP_SRA) it.imm = 16'd3;
      else it.imm = 16'hFFC5;
      it.pc = 16'hABCD;
      drive_word(it);
    end
    // bad opcode with incoming taken flag
    it.opcode = 5'd31;
    it.flags = 3'b100;
    it.imm = 16'h007F;
    it.pc = 16'hFFFF;
    drive_word(it);
    it = random_item();
    it.nop = 1'b1;
    drive_word(it);
    // add with jump
    it = random_item();
    it.nop = 1'b0;
    it.opcode = pes_pkg::OP_ADD;
    it.flags = 3'b010;
    drive_word(it);
    // sra by 16 on a negative operand, sll by a negative amount
    it.flags = 3'b000;
    it.tags = '0;
    it.opcode = pes_pkg::OP_SRA;
    it.rs_val = 16'h8000;
    it.imm = 16'd16;
    drive_word(it);
    it.opcode = pes_pkg::OP_SLL;
    it.rs_val = 16'h1234;
    it.imm = 16'hFFFF;
    drive_word(it);
    // bypass priority: all stages match, then MEM over WB
    it.opcode = pes_pkg::OP_ADD;
    it.instr = 16'h0090;
    it.ex_val = 16'h1111;
    it.mem_val = 16'h2222;
    it.wb_val = 16'h4444;
    it.tags = {1'b1, 3'd2, 1'b1, 3'd2, 1'b1, 3'd2};
    drive_word(it);
    it.tags = {1'b0, 3'd2, 1'b1, 3'd2, 1'b1, 3'd2};
    drive_word(it);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random(140, 30, 68);
    run_random(130, 68, 30);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 130; i++) drive_word(random_item());
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_pipeline_execute_stage_top: PASS");
    end else begin
      $display("tb_pipeline_execute_stage_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/pes_pkg.sv
hdl/pes_fwd.sv
hdl/pes_alu.sv
hdl/pipeline_execute_stage_top.sv
tb/pes_result_checker.sv
tb/tb_pipeline_execute_stage_top.sv
